/* rtl/core/wsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the weighted search priority block.
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int RES_BITS    = 26;
	localparam int WEIGHT_BITS = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [RES_BITS-1:0] RES_MAX = '1;

	typedef enum logic [1:0] {
		MODE_WA    = 2'd0,
		MODE_XDP   = 2'd1,
		MODE_XUP   = 2'd2,
		MODE_PWXDP = 2'd3
	} mode_t;

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_WEIGHT = 1'b1;

	typedef struct packed {
		logic inf;
		logic add_root;
	} ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/weighted_search_priority.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_search_priority
// Search priority from path cost and heuristic under four weighted formulas.
// ----------------------------------------------------------------------------
// One request is taken per cycle while full is low, and results come back in
// order. Each request runs through the square root pipeline (one root bit
// per stage) followed by the divider pipeline (one quotient bit per stage).
// Mode and weight are sampled when a request is taken.
module weighted_search_priority #(
	parameter int COST_BITS        = 24,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [2:0]                     paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire                            push,
	output logic                           full,
	input  wire  [COST_BITS-1:0]           g_cost,
	input  wire  [COST_BITS-1:0]           h_cost,
	input  wire                            h_infinite,
	output logic                           empty,
	input  wire                            pop,
	output logic [wsp_pkg::RES_BITS-1:0]   priority_res,
	output logic                           priority_infinite
);
	import wsp_pkg::*;

	localparam int RAD_W = 2*COST_BITS + 36;
	localparam int NUM_W = COST_BITS + 20;
	localparam int ADD_W = COST_BITS + 1;
	localparam int DEN_W = 18;
	localparam int CT_W  = $bits(ctrl_t);
	localparam int Q_W   = CT_W + RAD_W + NUM_W + ADD_W + DEN_W;

	mode_t                  mode_q;
	logic [WEIGHT_BITS-1:0] weight_q;

	logic             q_push, q_full, q_pop, q_empty;
	logic [Q_W-1:0]   q_wdata, q_rdata;
	ctrl_t            f_ctrl, b_ctrl;
	logic [RAD_W-1:0] f_rad, b_rad;
	logic [NUM_W-1:0] f_base, b_base;
	logic [ADD_W-1:0] f_addend, b_addend;
	logic [DEN_W-1:0] f_den, b_den;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WA;
			weight_q <= WEIGHT_BITS'(1 << WEIGHT_FRAC_BITS);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MODE:   mode_q   <= mode_t'(pwdata[1:0]);
				REG_WEIGHT: weight_q <= pwdata[WEIGHT_BITS-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:   prdata = 32'(mode_q);
			REG_WEIGHT: prdata = 32'(weight_q);
			default:    prdata = '0;
		endcase
	end

	wsp_front #(
		.COST_BITS        (COST_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.g_cost     (g_cost),
		.h_cost     (h_cost),
		.h_infinite (h_infinite),
		.cfg_mode   (mode_q),
		.cfg_weight (weight_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.out_ctrl   (f_ctrl),
		.out_rad    (f_rad),
		.out_base   (f_base),
		.out_addend (f_addend),
		.out_den    (f_den)
	);

	assign q_wdata = {f_ctrl, f_rad, f_base, f_addend, f_den};

	wsp_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	assign {b_ctrl, b_rad, b_base, b_addend, b_den} = q_rdata;

	wsp_back #(
		.COST_BITS        (COST_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.in_ctrl           (b_ctrl),
		.in_rad            (b_rad),
		.in_base           (b_base),
		.in_addend         (b_addend),
		.in_den            (b_den),
		.pop               (pop),
		.empty             (empty),
		.priority_res      (priority_res),
		.priority_infinite (priority_infinite)
	);

endmodule
`default_nettype wire

/* rtl/core/wsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_front
// Accepts requests, classifies them by mode and builds the radicand,
// numerator base, divisor and addend for the back end.
// ----------------------------------------------------------------------------
module wsp_front #(
	parameter  int COST_BITS        = 24,
	parameter  int WEIGHT_FRAC_BITS = 8,
	localparam int RAD_W            = 2*COST_BITS + 36,
	localparam int NUM_W            = COST_BITS + 20,
	localparam int ADD_W            = COST_BITS + 1,
	localparam int DEN_W            = 18
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	output logic                               full,
	input  wire  [COST_BITS-1:0]               g_cost,
	input  wire  [COST_BITS-1:0]               h_cost,
	input  wire                                h_infinite,
	input  wsp_pkg::mode_t                     cfg_mode,
	input  wire  [wsp_pkg::WEIGHT_BITS-1:0]    cfg_weight,
	input  wire                                q_full,
	output logic                               q_push,
	output wsp_pkg::ctrl_t                     out_ctrl,
	output logic [RAD_W-1:0]                   out_rad,
	output logic [NUM_W-1:0]                   out_base,
	output logic [ADD_W-1:0]                   out_addend,
	output logic [DEN_W-1:0]                   out_den
);
	import wsp_pkg::*;

	localparam int C     = COST_BITS;
	localparam int F     = WEIGHT_FRAC_BITS;
	localparam int WC_W  = 17;
	localparam int M1_W  = 2*C + 2;
	localparam int M2_W  = 2*C;
	localparam int WH_W  = C + 18;
	localparam int PP_W  = 2*C + 16;
	localparam int PS_W  = 2*C + 33;
	localparam logic [WC_W-1:0] S_V = WC_W'(1 << F);

	logic en;
	logic accept;

	// stage 1
	logic            v_s1;
	logic [C-1:0]    g_s1, h_s1;
	logic            inf_s1;
	mode_t           mode_s1;
	logic [WC_W-1:0] w_s1;
	logic [WC_W-1:0] w_cl;

	// stage 2
	logic            v_s2;
	logic [M1_W-1:0] m1_s2;
	logic [M2_W-1:0] m2_s2;
	logic [WH_W-1:0] wh_s2;
	logic [31:0]     coef_s2;
	logic [C-1:0]    g_s2, h_s2;
	logic [ADD_W-1:0] sum_s2;
	mode_t           mode_s2;
	logic            inf_s2;
	logic [WC_W-1:0] w_s2;
	logic            hgt_s2;

	// stage 3
	logic            v_s3;
	logic [PP_W-1:0] plo_s3, phi_s3;
	logic [M1_W-1:0] m1_s3;
	logic [NUM_W-1:0] base_s3;
	logic [ADD_W-1:0] addend_s3;
	logic [DEN_W-1:0] den_s3;
	ctrl_t           ctrl_s3;
	logic            userad_s3, xdp_s3;

	// stage 4
	logic            v_s4;
	logic [PS_W-1:0] prod_s4;
	logic [M1_W-1:0] m1_s4;
	logic [NUM_W-1:0] base_s4;
	logic [ADD_W-1:0] addend_s4;
	logic [DEN_W-1:0] den_s4;
	ctrl_t           ctrl_s4;
	logic            userad_s4, xdp_s4;

	// stage 5
	logic            v_s5;
	logic [RAD_W-1:0] rad_s5;
	logic [NUM_W-1:0] base_s5;
	logic [ADD_W-1:0] addend_s5;
	logic [DEN_W-1:0] den_s5;
	ctrl_t           ctrl_s5;

	// stage 1 to 2 terms
	logic            xdp1;
	logic [C-1:0]    d1, mlt1;
	logic [ADD_W-1:0] sum1, sqin1;
	logic [DEN_W-1:0] twm1;
	logic [WC_W-1:0] wws1;
	logic [33:0]     k1;

	// stage 2 to 3 terms
	logic [NUM_W-1:0] gsh2;
	logic [NUM_W-1:0] base2;
	logic [ADD_W-1:0] addend2;
	logic [DEN_W-1:0] den2;
	ctrl_t           ctrl2;

	assign en     = !(v_s5 && q_full);
	assign full   = !en;
	assign accept = push && !full;
	assign q_push = v_s5 && !q_full;

	assign w_cl = ({1'b0, cfg_weight} < S_V) ? S_V : {1'b0, cfg_weight};

	always_comb begin
		xdp1  = (mode_s1 == MODE_XDP);
		d1    = (g_s1 > h_s1) ? (g_s1 - h_s1) : (h_s1 - g_s1);
		sum1  = ADD_W'(g_s1) + ADD_W'(h_s1);
		sqin1 = xdp1 ? ADD_W'(d1) : sum1;
		mlt1  = xdp1 ? g_s1 : h_s1;
		twm1  = {w_s1, 1'b0} - DEN_W'(S_V);
		wws1  = w_s1 - S_V;
		k1    = 34'(w_s1) * 34'(wws1);
	end

	always_comb begin
		gsh2    = NUM_W'(g_s2) << F;
		base2   = '0;
		addend2 = '0;
		den2    = DEN_W'(w_s2);
		ctrl2   = '{inf: inf_s2, add_root: 1'b0};
		if (!inf_s2) begin
			case (mode_s2)
				MODE_WA: begin
					base2   = gsh2;
					addend2 = ADD_W'(h_s2);
				end
				MODE_XDP: begin
					base2          = NUM_W'(wh_s2) + gsh2;
					den2           = {w_s2, 1'b0};
					ctrl2.add_root = 1'b1;
				end
				MODE_XUP: begin
					base2          = NUM_W'(sum_s2) << F;
					den2           = {w_s2, 1'b0};
					ctrl2.add_root = 1'b1;
				end
				MODE_PWXDP: begin
					if (hgt_s2) begin
						addend2 = sum_s2;
					end else begin
						base2 = gsh2 + NUM_W'(wh_s2);
					end
				end
				default: begin
					base2 = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (accept) begin
				g_s1    <= g_cost;
				h_s1    <= h_cost;
				inf_s1  <= h_infinite;
				mode_s1 <= cfg_mode;
				w_s1    <= w_cl;
			end

			m1_s2   <= M1_W'(sqin1) * M1_W'(sqin1);
			m2_s2   <= M2_W'(mlt1) * M2_W'(h_s1);
			wh_s2   <= WH_W'(twm1) * WH_W'(h_s1);
			coef_s2 <= xdp1 ? 32'(w_s1) : k1[31:0];
			g_s2    <= g_s1;
			h_s2    <= h_s1;
			sum_s2  <= sum1;
			mode_s2 <= mode_s1;
			inf_s2  <= inf_s1;
			w_s2    <= w_s1;
			hgt_s2  <= (h_s1 > g_s1);

			plo_s3    <= PP_W'(m2_s2) * PP_W'(coef_s2[15:0]);
			phi_s3    <= PP_W'(m2_s2) * PP_W'(coef_s2[31:16]);
			m1_s3     <= m1_s2;
			base_s3   <= base2;
			addend_s3 <= addend2;
			den_s3    <= den2;
			ctrl_s3   <= ctrl2;
			userad_s3 <= !inf_s2 && (mode_s2 == MODE_XDP || mode_s2 == MODE_XUP);
			xdp_s3    <= (mode_s2 == MODE_XDP);

			prod_s4   <= PS_W'(plo_s3) + (PS_W'(phi_s3) << 16);
			m1_s4     <= m1_s3;
			base_s4   <= base_s3;
			addend_s4 <= addend_s3;
			den_s4    <= den_s3;
			ctrl_s4   <= ctrl_s3;
			userad_s4 <= userad_s3;
			xdp_s4    <= xdp_s3;

			if (userad_s4) begin
				rad_s5 <= (RAD_W'(m1_s4) << (2*F)) +
					(xdp_s4 ? (RAD_W'(prod_s4) << (F+2)) : (RAD_W'(prod_s4) << 2));
			end else begin
				rad_s5 <= '0;
			end
			base_s5   <= base_s4;
			addend_s5 <= addend_s4;
			den_s5    <= den_s4;
			ctrl_s5   <= ctrl_s4;
		end
	end

	assign out_ctrl   = ctrl_s5;
	assign out_rad    = rad_s5;
	assign out_base   = base_s5;
	assign out_addend = addend_s5;
	assign out_den    = den_s5;

endmodule
`default_nettype wire

/* rtl/core/wsp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module wsp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wr_data,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/wsp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_back
// Pipelined integer square root, pipelined division and saturation,
// with an output register toward the result side.
// ----------------------------------------------------------------------------
module wsp_back #(
	parameter  int COST_BITS        = 24,
	parameter  int WEIGHT_FRAC_BITS = 8,
	localparam int RAD_W            = 2*COST_BITS + 36,
	localparam int NUM_W            = COST_BITS + 20,
	localparam int ADD_W            = COST_BITS + 1,
	localparam int DEN_W            = 18
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               q_empty,
	output logic                              q_pop,
	input  wsp_pkg::ctrl_t                    in_ctrl,
	input  wire  [RAD_W-1:0]                  in_rad,
	input  wire  [NUM_W-1:0]                  in_base,
	input  wire  [ADD_W-1:0]                  in_addend,
	input  wire  [DEN_W-1:0]                  in_den,
	input  wire                               pop,
	output logic                              empty,
	output logic [wsp_pkg::RES_BITS-1:0]      priority_res,
	output logic                              priority_infinite
);
	import wsp_pkg::*;

	localparam int ROOT_W = COST_BITS + 18;
	localparam int QW     = NUM_W - WEIGHT_FRAC_BITS;
	localparam int SUM_W  = QW + 1;
	localparam int EXT_W  = (SUM_W > RES_BITS) ? SUM_W : RES_BITS;

	logic en;

	// square root stages
	logic              sq_v_s      [0:ROOT_W];
	logic [RAD_W-1:0]  sq_rad_s    [0:ROOT_W];
	logic [ROOT_W:0]   sq_rem_s    [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root_s   [0:ROOT_W];
	logic [NUM_W-1:0]  sq_base_s   [0:ROOT_W];
	logic [ADD_W-1:0]  sq_addend_s [0:ROOT_W];
	logic [DEN_W-1:0]  sq_den_s    [0:ROOT_W];
	ctrl_t             sq_ctrl_s   [0:ROOT_W];

	// division stages
	logic              dv_v_s      [0:QW];
	logic [DEN_W-1:0]  dv_rem_s    [0:QW];
	logic [QW-1:0]     dv_nb_s     [0:QW];
	logic [DEN_W-1:0]  dv_den_s    [0:QW];
	logic [ADD_W-1:0]  dv_addend_s [0:QW];
	logic              dv_inf_s    [0:QW];

	logic                out_v_q;
	logic [RES_BITS-1:0] res_q;
	logic                inf_q;

	logic [NUM_W-1:0] num;
	logic [SUM_W-1:0] total;
	logic [EXT_W-1:0] total_ext;

	assign en    = !out_v_q || pop;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en && q_pop) begin
			sq_rad_s[0]    <= in_rad;
			sq_rem_s[0]    <= '0;
			sq_root_s[0]   <= '0;
			sq_base_s[0]   <= in_base;
			sq_addend_s[0] <= in_addend;
			sq_den_s[0]    <= in_den;
			sq_ctrl_s[0]   <= in_ctrl;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [ROOT_W+2:0] cur, trial;
		logic              ge;

		assign cur   = {sq_rem_s[k], sq_rad_s[k][RAD_W-1 -: 2]};
		assign trial = {1'b0, sq_root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k+1]    <= sq_rad_s[k] << 2;
				sq_rem_s[k+1]    <= ge ? (ROOT_W+1)'(cur - trial) : (ROOT_W+1)'(cur);
				sq_root_s[k+1]   <= {sq_root_s[k][ROOT_W-2:0], ge};
				sq_base_s[k+1]   <= sq_base_s[k];
				sq_addend_s[k+1] <= sq_addend_s[k];
				sq_den_s[k+1]    <= sq_den_s[k];
				sq_ctrl_s[k+1]   <= sq_ctrl_s[k];
			end
		end
	end

	assign num = sq_base_s[ROOT_W] +
		(sq_ctrl_s[ROOT_W].add_root ? NUM_W'(sq_root_s[ROOT_W]) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0]    <= DEN_W'(num >> QW);
			dv_nb_s[0]     <= num[QW-1:0];
			dv_den_s[0]    <= sq_den_s[ROOT_W];
			dv_addend_s[0] <= sq_addend_s[ROOT_W];
			dv_inf_s[0]    <= sq_ctrl_s[ROOT_W].inf;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [DEN_W:0] cur;
		logic           ge;

		assign cur = {dv_rem_s[j], dv_nb_s[j][QW-1]};
		assign ge  = (cur >= {1'b0, dv_den_s[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1]    <= ge ? DEN_W'(cur - {1'b0, dv_den_s[j]}) : DEN_W'(cur);
				dv_nb_s[j+1]     <= {dv_nb_s[j][QW-2:0], ge};
				dv_den_s[j+1]    <= dv_den_s[j];
				dv_addend_s[j+1] <= dv_addend_s[j];
				dv_inf_s[j+1]    <= dv_inf_s[j];
			end
		end
	end

	assign total     = SUM_W'(dv_nb_s[QW]) + SUM_W'(dv_addend_s[QW]);
	assign total_ext = EXT_W'(total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inf_q <= dv_inf_s[QW];
			if (total_ext > EXT_W'(RES_MAX)) begin
				res_q <= RES_MAX;
			end else begin
				res_q <= RES_BITS'(total_ext);
			end
		end
	end

	assign empty             = !out_v_q;
	assign priority_res      = res_q;
	assign priority_infinite = inf_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[QW] |-> (dv_rem_s[QW] < dv_den_s[QW]))
		else $error("division remainder not below divisor");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[ROOT_W] |-> (sq_rem_s[ROOT_W] <= {sq_root_s[ROOT_W], 1'b0}))
		else $error("square root remainder out of range");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && inf_q) |-> (res_q == '0))
		else $error("infinite result with nonzero value");

endmodule
`default_nettype wire
